// ===== hw/rtl/ips_patch_stream_decoder_assert.svh =====
// Assertion macros shared by the patch stream decoder RTL.
`ifndef IPS_PATCH_STREAM_DECODER_ASSERT_SVH
`define IPS_PATCH_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define IPSD_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ipsd assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define IPSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ipsd assertion failed");

`endif

// ===== hw/rtl/ipsd_pkg.sv =====
// Types and constants of the patch stream decoder.
package ipsd_pkg;

  localparam logic [31:0] TailNarrow = 32'h0045_4F46;  // "EOF"
  localparam logic [31:0] TailWide   = 32'h4545_4F46;  // "EEOF"

  typedef enum logic [1:0] {
    CFG_WIDE_OFFSETS = 2'd0,
    CFG_GUARD_SIZE   = 2'd1,
    CFG_BASE_OFFSET  = 2'd2,
    CFG_TARGET_SIZE  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_FILL  = 2'd1,
    KIND_ENDED = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  typedef struct packed {
    logic        wide_offsets;
    logic [31:0] guard_size;
    logic [31:0] base_offset;
    logic [31:0] target_size;
  } cfg_t;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       stream_start;
    logic       stream_last;
  } item_t;

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [31:0] target_address;
    logic [15:0] run_length;
    logic [7:0]  write_value;
  } result_t;

endpackage

// ===== hw/rtl/ips_patch_stream_decoder.sv =====
// Top level of the IPS / IPS32 patch stream decoder.
// Takes one patch body byte per cycle while in_stall_o is low and gives at most one
// result per byte: a byte write, a fill run, patch end or an error. The record parser
// takes one byte per clock when nothing stalls; a result is on the outputs once its
// byte has passed the input register and then the result register. A stall on the
// result side reaches in_stall_o in the same cycle once both registers are full.
// Configuration is written through the plain write port; the user must do so only
// while no byte is in flight, as the block itself does not enforce it.
`include "ips_patch_stream_decoder_assert.svh"

module ips_patch_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  stream_byte_i,
  input  logic        stream_start_i,
  input  logic        stream_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [31:0] target_address_o,
  output logic [15:0] run_length_o,
  output logic [7:0]  write_value_o
);
  import ipsd_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  logic    in_valid_q, in_valid_d;
  logic    in_accept, fire;
  result_t res, out_res;

  ipsd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // parse the held request whenever the result register can take its outcome
  assign fire       = in_valid_q && !(out_valid_o && out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_o && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.stream_byte  <= stream_byte_i;
      item_q.stream_start <= stream_start_i;
      item_q.stream_last  <= stream_last_i;
    end
  end

  ipsd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  ipsd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (out_res)
  );

  assign kind_o           = out_res.kind;
  assign target_address_o = out_res.target_address;
  assign run_length_o     = out_res.run_length;
  assign write_value_o    = out_res.write_value;

  `IPSD_ASSERT(a_stall_cause, in_stall_o, in_valid_q && out_valid_o && out_stall_i)
  `IPSD_ASSERT(a_write_len, out_valid_o && (kind_o == KIND_WRITE), run_length_o == 16'd1)
  `IPSD_ASSERT(a_fill_len, out_valid_o && (kind_o == KIND_FILL), run_length_o != 16'd0)
  `IPSD_ASSERT(a_status_zero,
               out_valid_o && ((kind_o == KIND_ENDED) || (kind_o == KIND_ERROR)),
               (target_address_o == 32'd0) && (run_length_o == 16'd0))

endmodule

// ===== hw/rtl/ipsd_cfg_regs.sv =====
// Configuration registers of the patch stream decoder.
module ipsd_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_wdata_i,
  output ipsd_pkg::cfg_t      cfg_o
);
  import ipsd_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_WIDE_OFFSETS: cfg_d.wide_offsets = cfg_wdata_i[0];
        CFG_GUARD_SIZE:   cfg_d.guard_size   = cfg_wdata_i;
        CFG_BASE_OFFSET:  cfg_d.base_offset  = cfg_wdata_i;
        CFG_TARGET_SIZE:  cfg_d.target_size  = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/ipsd_parser.sv =====
// Record parser: field assembly, address window checks and result build.
`include "ips_patch_stream_decoder_assert.svh"

module ipsd_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  ipsd_pkg::item_t   item_i,
  input  ipsd_pkg::cfg_t    cfg_i,
  output ipsd_pkg::result_t res_o
);
  import ipsd_pkg::*;

  typedef enum logic [6:0] {
    PH_OFFSET    = 7'b0000001,
    PH_SIZE      = 7'b0000010,
    PH_RUN_COUNT = 7'b0000100,
    PH_RUN_VALUE = 7'b0001000,
    PH_DATA      = 7'b0010000,
    PH_ENDED     = 7'b0100000,
    PH_ERROR     = 7'b1000000
  } phase_e;

  phase_e      phase_q, phase_d, cur_phase;
  logic [1:0]  fbc_q, fbc_d, cur_fbc, fbc_inc;
  logic [31:0] addr_q, addr_d, cur_addr;
  logic [15:0] len_q, len_d, cur_len;
  logic [15:0] left_q, left_d, cur_left;
  logic [32:0] ptr_q, ptr_d;
  logic        off_done;
  logic [31:0] tail;
  logic [32:0] prot33, base33, tgt33;
  logic [32:0] run_end, run_start, run_t, run_te, run_te_c, data_t;
  logic        run_keep;
  logic [32:0] run_len33;
  result_t     res;

  assign prot33 = {1'b0, cfg_i.guard_size};
  assign base33 = {1'b0, cfg_i.base_offset};
  assign tgt33  = {1'b0, cfg_i.target_size};
  assign tail   = cfg_i.wide_offsets ? TailWide : TailNarrow;

  // start restarts the parser before this byte is parsed
  always_comb begin
    if (item_i.stream_start) begin
      cur_phase = PH_OFFSET;
      cur_fbc   = '0;
      cur_addr  = '0;
      cur_len   = '0;
      cur_left  = '0;
    end else begin
      cur_phase = phase_q;
      cur_fbc   = fbc_q;
      cur_addr  = addr_q;
      cur_len   = len_q;
      cur_left  = left_q;
    end
  end

  // run span: begins at max(offset, protected), ends at offset + count
  always_comb begin
    run_end   = {1'b0, cur_addr} + {17'd0, cur_len};
    run_start = ({1'b0, cur_addr} < prot33) ? prot33 : {1'b0, cur_addr};
    run_keep  = !(({1'b0, cur_addr} < prot33) && (run_end <= prot33));
    run_t     = run_start - base33;
    run_te    = run_end - base33;
    run_te_c  = (run_te > tgt33) ? tgt33 : run_te;
    run_len33 = run_te_c - run_t;
    data_t    = ptr_q - base33;
  end

  assign fbc_inc  = cur_fbc + 2'd1;
  assign off_done = (fbc_inc == 2'd0) || (!cfg_i.wide_offsets && (fbc_inc == 2'd3));

  always_comb begin
    phase_d = phase_q;
    fbc_d   = fbc_q;
    addr_d  = addr_q;
    len_d   = len_q;
    left_d  = left_q;
    ptr_d   = ptr_q;
    res     = '0;
    if (fire_i) begin
      phase_d = cur_phase;
      fbc_d   = cur_fbc;
      addr_d  = cur_addr;
      len_d   = cur_len;
      left_d  = cur_left;
      if ((cur_phase == PH_ENDED) || (cur_phase == PH_ERROR)) begin
        // parked until the next start
      end else if (cfg_i.base_offset > cfg_i.guard_size) begin
        phase_d   = PH_ERROR;
        res.valid = 1'b1;
        res.kind  = KIND_ERROR;
      end else begin
        unique case (cur_phase)
          PH_OFFSET: begin
            addr_d = {cur_addr[23:0], item_i.stream_byte};
            fbc_d  = fbc_inc;
            if (off_done) begin
              fbc_d = '0;
              if (!cfg_i.wide_offsets) addr_d[31:24] = '0;
              if (addr_d == tail) begin
                phase_d   = PH_ENDED;
                res.valid = 1'b1;
                res.kind  = KIND_ENDED;
              end else begin
                len_d   = '0;
                phase_d = PH_SIZE;
              end
            end
          end
          PH_SIZE: begin
            len_d = {cur_len[7:0], item_i.stream_byte};
            fbc_d = fbc_inc;
            if (cur_fbc != 2'd0) begin
              fbc_d = '0;
              if (len_d == 16'd0) begin
                phase_d = PH_RUN_COUNT;
              end else begin
                left_d  = len_d;
                ptr_d   = {1'b0, cur_addr};
                phase_d = PH_DATA;
              end
            end
          end
          PH_RUN_COUNT: begin
            len_d = {cur_len[7:0], item_i.stream_byte};
            fbc_d = fbc_inc;
            if (cur_fbc != 2'd0) begin
              fbc_d   = '0;
              phase_d = PH_RUN_VALUE;
            end
          end
          PH_RUN_VALUE: begin
            phase_d = PH_OFFSET;
            if (run_keep && (run_t < run_te_c)) begin
              res.valid          = 1'b1;
              res.kind           = KIND_FILL;
              res.target_address = run_t[31:0];
              res.run_length     = run_len33[15:0];
              res.write_value    = item_i.stream_byte;
            end
          end
          PH_DATA: begin
            ptr_d  = ptr_q + 33'd1;
            left_d = cur_left - 16'd1;
            if (left_d == 16'd0) phase_d = PH_OFFSET;
            if ((ptr_q >= prot33) && (data_t < tgt33)) begin
              res.valid          = 1'b1;
              res.kind           = KIND_WRITE;
              res.target_address = data_t[31:0];
              res.run_length     = 16'd1;
              res.write_value    = item_i.stream_byte;
            end
          end
          default: ;
        endcase
        // early end of stream overrides whatever this byte gave
        if (item_i.stream_last && (phase_d != PH_ENDED)) begin
          phase_d   = PH_ERROR;
          res       = '0;
          res.valid = 1'b1;
          res.kind  = KIND_ERROR;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_OFFSET;
      fbc_q   <= '0;
      addr_q  <= '0;
      len_q   <= '0;
      left_q  <= '0;
    end else begin
      phase_q <= phase_d;
      fbc_q   <= fbc_d;
      addr_q  <= addr_d;
      len_q   <= len_d;
      left_q  <= left_d;
    end
  end

  // data pointer is loaded before use in every record
  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
  end

  assign res_o = res;

  `IPSD_ASSERT_NEXT(a_ended_parks, res.valid && (res.kind == KIND_ENDED), phase_q == PH_ENDED)
  `IPSD_ASSERT_NEXT(a_error_parks, res.valid && (res.kind == KIND_ERROR), phase_q == PH_ERROR)
  `IPSD_ASSERT(a_data_left, phase_q == PH_DATA, left_q != 16'd0)

endmodule

// ===== hw/rtl/ipsd_out_stage.sv =====
// Result register of the patch stream decoder.
module ipsd_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  ipsd_pkg::result_t res_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output ipsd_pkg::result_t res_o
);
  import ipsd_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  always_comb begin
    valid_d = valid_q;
    if (fire_i) begin
      valid_d = res_i.valid;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && res_i.valid) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ===== sim/tb_ips_patch_stream_decoder.sv =====
// Self-checking testbench for the IPS / IPS32 patch stream decoder.
module tb_ips_patch_stream_decoder;
  import ipsd_pkg::*;

  localparam int RandomBytes = 2000;
  localparam int SettleCycles = 6;
  localparam int CycleLimit = 200000;

  typedef enum logic [2:0] {
    PS_OFFSET, PS_SIZE, PS_RUN_COUNT, PS_RUN_VALUE, PS_DATA, PS_ENDED, PS_ERROR
  } parse_state_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  stream_byte_i = '0;
  logic        stream_start_i = 1'b0;
  logic        stream_last_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  kind_o;
  logic [31:0] target_address_o;
  logic [15:0] run_length_o;
  logic [7:0]  write_value_o;

  ips_patch_stream_decoder uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .stream_byte_i    (stream_byte_i),
    .stream_start_i   (stream_start_i),
    .stream_last_i    (stream_last_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .target_address_o (target_address_o),
    .run_length_o     (run_length_o),
    .write_value_o    (write_value_o)
  );

  // Shadow of the registers and of the record parser
  cfg_t         cfg_shadow = '0;
  parse_state_e dec_state = PS_OFFSET;
  logic [1:0]   field_cnt = '0;
  logic [31:0]  rec_offset = '0;
  logic [15:0]  rec_size = '0;
  logic [15:0]  literal_left = '0;

  result_t    pending_results[$];
  logic [7:0] patch_bytes[$];
  int         bytes_sent = 0;
  int         mismatches = 0;
  int         cycle_count = 0;
  bit         gaps_on = 1'b1;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("ips_patch_stream_decoder verification failed");
      $finish;
    end
  end

  always @(negedge clk_i) out_stall_i <= gaps_on && ($urandom_range(0, 99) < 32);

  // Works out the result that one accepted byte gives, advancing the shadow parser
  function automatic bit decode_byte(input logic [7:0] b, input logic first,
                                     input logic final_byte, output result_t r);
    logic [63:0] prot, base, tsize, span_lo, span_hi, tgt_lo, tgt_hi, addr;
    logic [31:0] tail;
    bit hit;
    r = '0;
    r.valid = 1'b1;
    hit = 1'b0;
    prot = 64'(cfg_shadow.guard_size);
    base = 64'(cfg_shadow.base_offset);
    tsize = 64'(cfg_shadow.target_size);
    if (first) begin
      dec_state = PS_OFFSET;
      field_cnt = '0;
      rec_offset = '0;
      rec_size = '0;
      literal_left = '0;
    end
    if (dec_state == PS_ENDED || dec_state == PS_ERROR) return 1'b0;
    if (cfg_shadow.base_offset > cfg_shadow.guard_size) begin
      dec_state = PS_ERROR;
      r.kind = KIND_ERROR;
      return 1'b1;
    end
    case (dec_state)
      PS_OFFSET: begin
        rec_offset = {rec_offset[23:0], b};
        field_cnt = field_cnt + 2'd1;
        // complete once the current mode has enough bytes, even after a mode switch
        if (field_cnt == 2'd0 || (!cfg_shadow.wide_offsets && field_cnt == 2'd3)) begin
          field_cnt = '0;
          if (!cfg_shadow.wide_offsets) rec_offset[31:24] = '0;
          tail = cfg_shadow.wide_offsets ? TailWide : TailNarrow;
          if (rec_offset == tail) begin
            dec_state = PS_ENDED;
            r.kind = KIND_ENDED;
            hit = 1'b1;
          end else begin
            rec_size = '0;
            dec_state = PS_SIZE;
          end
        end
      end
      PS_SIZE: begin
        rec_size = {rec_size[7:0], b};
        field_cnt = field_cnt + 2'd1;
        if (field_cnt == 2'd2) begin
          field_cnt = '0;
          if (rec_size == '0) begin
            dec_state = PS_RUN_COUNT;
          end else begin
            literal_left = rec_size;
            dec_state = PS_DATA;
          end
        end
      end
      PS_RUN_COUNT: begin
        rec_size = {rec_size[7:0], b};
        field_cnt = field_cnt + 2'd1;
        if (field_cnt == 2'd2) begin
          field_cnt = '0;
          dec_state = PS_RUN_VALUE;
        end
      end
      PS_RUN_VALUE: begin
        dec_state = PS_OFFSET;
        span_lo = 64'(rec_offset);
        span_hi = span_lo + 64'(rec_size);
        if (span_hi > prot) begin
          if (span_lo < prot) span_lo = prot;
          tgt_lo = span_lo - base;
          tgt_hi = span_hi - base;
          if (tgt_hi > tsize) tgt_hi = tsize;
          if (tgt_lo < tgt_hi) begin
            r.kind = KIND_FILL;
            r.target_address = tgt_lo[31:0];
            r.run_length = 16'(tgt_hi - tgt_lo);
            r.write_value = b;
            hit = 1'b1;
          end
        end
      end
      PS_DATA: begin
        addr = 64'(rec_offset) + 64'(16'(rec_size - literal_left));
        literal_left = literal_left - 16'd1;
        if (literal_left == '0) dec_state = PS_OFFSET;
        if (addr >= prot) begin
          tgt_lo = addr - base;
          if (tgt_lo < tsize) begin
            r.kind = KIND_WRITE;
            r.target_address = tgt_lo[31:0];
            r.run_length = 16'd1;
            r.write_value = b;
            hit = 1'b1;
          end
        end
      end
      default: ;
    endcase
    // stream ran out before the tail: error replaces anything this byte gave
    if (final_byte && dec_state != PS_ENDED) begin
      dec_state = PS_ERROR;
      r = '0;
      r.valid = 1'b1;
      r.kind = KIND_ERROR;
      hit = 1'b1;
    end
    return hit;
  endfunction

  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d address %h", kind_o, target_address_o);
        mismatches++;
      end else begin
        exp_r = pending_results.pop_front();
        if (kind_o !== exp_r.kind) begin
          $error("kind: expected %0d, got %0d", exp_r.kind, kind_o);
          mismatches++;
        end
        if (target_address_o !== exp_r.target_address) begin
          $error("target_address: expected %h, got %h", exp_r.target_address,
                 target_address_o);
          mismatches++;
        end
        if (run_length_o !== exp_r.run_length) begin
          $error("run_length: expected %0d, got %0d", exp_r.run_length, run_length_o);
          mismatches++;
        end
        if (write_value_o !== exp_r.write_value) begin
          $error("write_value: expected %h, got %h", exp_r.write_value, write_value_o);
          mismatches++;
        end
      end
    end
  end

  // One byte request; returns just after the edge that accepted it
  task automatic send_byte(input logic [7:0] b, input logic first, input logic final_byte);
    result_t r;
    @(negedge clk_i);
    while (gaps_on && $urandom_range(0, 99) < 32) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    stream_byte_i <= b;
    stream_start_i <= first;
    stream_last_i <= final_byte;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (decode_byte(b, first, final_byte, r)) pending_results.push_back(r);
    bytes_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    // bytes without a result may still be in the pipe
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_WIDE_OFFSETS: cfg_shadow.wide_offsets = val[0];
      CFG_GUARD_SIZE:   cfg_shadow.guard_size = val;
      CFG_BASE_OFFSET:  cfg_shadow.base_offset = val;
      default:          cfg_shadow.target_size = val;
    endcase
  endtask

  task automatic apply_config(input logic wide, input logic [31:0] prot,
                              input logic [31:0] base, input logic [31:0] tsize);
    wait_idle();
    write_reg(CFG_WIDE_OFFSETS, {31'b0, wide});
    write_reg(CFG_GUARD_SIZE, prot);
    write_reg(CFG_BASE_OFFSET, base);
    write_reg(CFG_TARGET_SIZE, tsize);
  endtask

  task automatic push_random_bytes(input int n);
    repeat (n) patch_bytes.push_back(8'($urandom));
  endtask

  task automatic put_offset(input logic [31:0] addr);
    if (cfg_shadow.wide_offsets) patch_bytes.push_back(addr[31:24]);
    patch_bytes.push_back(addr[23:16]);
    patch_bytes.push_back(addr[15:8]);
    patch_bytes.push_back(addr[7:0]);
  endtask

  task automatic put_literal(input logic [31:0] addr, input logic [15:0] len);
    put_offset(addr);
    patch_bytes.push_back(len[15:8]);
    patch_bytes.push_back(len[7:0]);
    push_random_bytes(len);
  endtask

  task automatic put_run(input logic [31:0] addr, input logic [15:0] cnt,
                         input logic [7:0] val);
    put_offset(addr);
    patch_bytes.push_back(8'h00);
    patch_bytes.push_back(8'h00);
    patch_bytes.push_back(cnt[15:8]);
    patch_bytes.push_back(cnt[7:0]);
    patch_bytes.push_back(val);
  endtask

  task automatic put_tail();
    put_offset(cfg_shadow.wide_offsets ? TailWide : TailNarrow);
  endtask

  task automatic play_patch(input bit mark_last, input bit with_start);
    foreach (patch_bytes[i])
      send_byte(patch_bytes[i], with_start && i == 0,
                mark_last && i == patch_bytes.size() - 1);
    patch_bytes.delete();
  endtask

  function automatic logic [31:0] pick_patch_addr();
    logic [31:0] delta;
    delta = 32'($urandom_range(0, 64)) - 32'd32;
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return cfg_shadow.guard_size + delta;
      2: return cfg_shadow.base_offset + cfg_shadow.target_size + delta;
      3: return cfg_shadow.base_offset + delta;
      default: return $urandom_range(0, 1) ? delta : 32'hFFFF_FFE0 + delta;
    endcase
  endfunction

  // Registers at reset: empty target, so only the tail gives a result
  task automatic test_reset_values();
    put_literal(32'h0, 16'd1);
    put_tail();
    play_patch(1'b1, 1'b1);
  endtask

  task automatic test_literal_edges();
    apply_config(1'b0, 32'h100, 32'h80, 32'h100);
    put_literal(32'hFE, 16'd3);   // straddles the protected boundary
    put_literal(32'h17F, 16'd2);  // straddles the end of the target
    put_tail();
    play_patch(1'b1, 1'b1);
  endtask

  task automatic test_run_clipping();
    put_run(32'hF0, 16'h20, 8'hFF);   // start clamped to protected size
    put_run(32'h170, 16'h40, 8'h00);  // end clipped to target size
    put_run(32'h10, 16'h20, 8'h11);   // wholly protected
    put_run(32'h200, 16'h5, 8'h22);   // starts past the target
    put_run(32'h120, 16'h0, 8'h33);   // empty count
    put_tail();
    play_patch(1'b1, 1'b1);
  endtask

  task automatic test_wide_extremes();
    apply_config(1'b1, 32'h0, 32'h0, 32'hFFFF_FFFF);
    put_literal(32'hFFFF_FFFE, 16'd2);
    put_run(32'hFFFF_FFF0, 16'hFFFF, 8'h5A);
    put_literal(32'h0, 16'd1);
    put_tail();
    play_patch(1'b1, 1'b1);
    // sums past 32 bits must not wrap
    apply_config(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    put_literal(32'hFFFF_FFFF, 16'd1);
    put_run(32'hFFFF_FFFE, 16'd3, 8'hA5);
    put_tail();
    play_patch(1'b1, 1'b1);
  endtask

  task automatic test_bad_base();
    apply_config(1'b0, 32'h10, 32'h11, 32'h100);
    put_literal(32'h20, 16'd1);
    play_patch(1'b1, 1'b1);
    put_tail();
    play_patch(1'b0, 1'b1);
  endtask

  task automatic test_early_end();
    apply_config(1'b0, 32'h0, 32'h0, 32'hFFFF_FFFF);
    put_literal(32'h10, 16'd3);  // last flag on a byte that would write
    play_patch(1'b1, 1'b1);
    put_offset(32'h5);
    play_patch(1'b1, 1'b1);
    put_run(32'h40, 16'd4, 8'hC3);
    play_patch(1'b1, 1'b1);
    put_tail();                  // bytes after the tail are ignored
    push_random_bytes(3);
    play_patch(1'b1, 1'b1);
  endtask

  task automatic test_mode_change();
    apply_config(1'b1, 32'h0, 32'h0, 32'h1000);
    patch_bytes = {8'h00, 8'h00};
    play_patch(1'b0, 1'b1);
    wait_idle();
    write_reg(CFG_WIDE_OFFSETS, 32'd0);
    patch_bytes = {8'h10, 8'h00, 8'h01, 8'h77};
    put_tail();
    play_patch(1'b1, 1'b0);
    patch_bytes = {8'h00, 8'h00};
    play_patch(1'b0, 1'b1);
    wait_idle();
    write_reg(CFG_WIDE_OFFSETS, 32'd1);
    patch_bytes = {8'h00, 8'h20, 8'h00, 8'h01, 8'h66};
    put_tail();
    play_patch(1'b1, 1'b0);
  endtask

  task automatic send_random_patch();
    int nrec;
    int ending;
    int cut;
    bit mark_last;
    logic [15:0] cnt;
    nrec = $urandom_range(0, 5);
    repeat (nrec) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 3))
          0: cnt = 16'd0;
          1: cnt = 16'hFFFF;
          2: cnt = 16'($urandom);
          default: cnt = 16'($urandom_range(1, 80));
        endcase
        put_run(pick_patch_addr(), cnt, 8'($urandom));
      end else begin
        put_literal(pick_patch_addr(), ($urandom_range(0, 9) == 0) ?
                    16'($urandom_range(7, 40)) : 16'($urandom_range(1, 6)));
      end
    end
    ending = $urandom_range(0, 99);
    mark_last = 1'b1;
    if (ending < 70) begin
      put_tail();
      if ($urandom_range(0, 4) == 0) push_random_bytes($urandom_range(1, 4));
      mark_last = $urandom_range(0, 4) != 0;
    end else if (ending < 85) begin
      // truncated patch
      if (patch_bytes.size() == 0) push_random_bytes(1);
      cut = $urandom_range(1, patch_bytes.size());
      patch_bytes = patch_bytes[0:cut-1];
    end else begin
      push_random_bytes($urandom_range(1, 12));
      mark_last = 1'($urandom_range(0, 1));
    end
    play_patch(mark_last, 1'b1);
  endtask

  task automatic test_random_patches();
    int phase_no;
    int start_count;
    logic wide;
    logic [31:0] span, prot, base, tsize, delta;
    phase_no = 0;
    start_count = bytes_sent;
    while (bytes_sent - start_count < RandomBytes) begin
      wide = 1'($urandom_range(0, 1));
      span = wide ? 32'hFFFF_FFFF : 32'h00FF_FFFF;
      case ($urandom_range(0, 4))
        0: prot = 32'd0;
        1: prot = span;
        2: prot = $urandom & span;
        default: prot = $urandom_range(0, 512);
      endcase
      delta = $urandom_range(0, 300);
      case ($urandom_range(0, 9))
        0: base = prot + 32'd1 + $urandom_range(0, 15);
        1: base = prot;
        2: base = 32'd0;
        default: base = (delta > prot) ? 32'd0 : prot - delta;
      endcase
      case ($urandom_range(0, 4))
        0: tsize = 32'd0;
        1: tsize = 32'hFFFF_FFFF;
        2: tsize = $urandom;
        default: tsize = $urandom_range(1, 512);
      endcase
      apply_config(wide, prot, base, tsize);
      gaps_on = (phase_no % 7) != 3;
      repeat ($urandom_range(3, 8)) send_random_patch();
      phase_no++;
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_values();
    test_literal_edges();
    test_run_clipping();
    test_wide_extremes();
    test_bad_base();
    test_early_end();
    test_mode_change();
    test_random_patches();
    wait_idle();
    if (mismatches == 0) begin
      $display("ips_patch_stream_decoder verification clean");
    end else begin
      $display("ips_patch_stream_decoder verification failed");
    end
    $finish;
  end

endmodule
